@@ rtl/jps_pkg.sv @@
// jps_pkg: shared types and codes of the jacobi poisson stencil solver
// depends on nothing; used by every module of the block
`default_nettype none

package jps_pkg;

	// command codes
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_SOLVE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// result status codes
	localparam logic [2:0] ST_LOADED = 3'd0;
	localparam logic [2:0] ST_CONV   = 3'd1;
	localparam logic [2:0] ST_LIMIT  = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_BAD    = 3'd4;

	// per-point phases of a sweep
	localparam logic [3:0] PH_N   = 4'd0;
	localparam logic [3:0] PH_S   = 4'd1;
	localparam logic [3:0] PH_W   = 4'd2;
	localparam logic [3:0] PH_E   = 4'd3;
	localparam logic [3:0] PH_C   = 4'd4;
	localparam logic [3:0] PH_ACC = 4'd5;
	localparam logic [3:0] PH_LO  = 4'd6;
	localparam logic [3:0] PH_HI  = 4'd7;
	localparam logic [3:0] PH_RES = 4'd8;
	localparam logic [3:0] PH_WR  = 4'd9;

	typedef struct packed {
		logic [1:0]         command;
		logic [6:0]         row;
		logic [6:0]         col;
		logic signed [31:0] initial_u;
		logic signed [31:0] source_f;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] u_value;
		logic [15:0]        iterations;
		logic [31:0]        max_change;
	} rsp_t;

	typedef struct packed {
		logic       capture;
		logic       load_we;
		logic       sweep;
		logic [3:0] phase;
		logic       interior;
		logic       clear_worst;
		logic       swap;
		logic       keep_change;
		logic       out_load;
		logic [2:0] status;
	} jps_dcmd_t;

	typedef struct packed {
		logic le_tol;
	} jps_dstat_t;

endpackage

`default_nettype wire

@@ rtl/jps_datapath.sv @@
// jps_datapath: grid memories, stencil arithmetic and result register
// depends on jps_pkg; driven by jps_ctrl
`default_nettype none

module jps_datapath #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 128,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  jps_pkg::jps_dcmd_t                        dcmd,
	input  logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0]   addr,
	input  jps_pkg::cmd_t                             cmd,
	input  logic [31:0]                               inv_dx,
	input  logic [31:0]                               inv_dy,
	input  logic [31:0]                               coef,
	input  logic [30:0]                               tol,
	input  logic [15:0]                               sweep_count,
	output jps_pkg::jps_dstat_t                       dstat,
	output jps_pkg::rsp_t                             rsp
);
	import jps_pkg::*;

	localparam int AW    = $clog2(MAX_COLUMNS*MAX_ROWS);
	localparam int DEPTH = MAX_COLUMNS*MAX_ROWS;
	localparam int SW    = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
	localparam logic signed [63:0] SAT_MAX = (64'sd1 <<< (SW-1)) - 64'sd1;
	localparam logic signed [63:0] SAT_MIN = -SAT_MAX - 64'sd1;

	function automatic logic [31:0] sat_val(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > SAT_MAX) r = SAT_MAX[31:0];
		else if (v < SAT_MIN) r = SAT_MIN[31:0];
		else r = v[31:0];
		return r;
	endfunction

	logic [31:0] mem_a [DEPTH];
	logic [31:0] mem_b [DEPTH];
	logic [31:0] mem_f [DEPTH];

	logic [31:0] rd_a, rd_b, rd_f, cur_rd;
	logic [31:0] u_in_q, f_in_q;
	logic        cur_sel_q;
	logic [AW-1:0] raddr;
	logic        we_a, we_b, sweep_wr;
	logic [31:0] wr_val;

	logic [31:0]        inv_sel;
	logic signed [64:0] prod_c;
	logic signed [63:0] prod_q, term;
	logic signed [59:0] acc_q;
	logic [59:0]        mag;
	logic [63:0]        prodlo_q;
	logic [59:0]        prodhi_q;
	logic [60:0]        qsum;
	logic signed [63:0] qval;
	logic [31:0]        new_q, center_q;
	logic [32:0]        diff, absd_w;
	logic [31:0]        absd, worst_q, largest_q;
	rsp_t               rsp_q;

	// read address: stencil taps during a sweep, else the load/read point
	always_comb begin
		raddr = addr;
		if (dcmd.sweep) begin
			case (dcmd.phase)
				PH_N:    raddr = addr - AW'(MAX_COLUMNS);
				PH_S:    raddr = addr + AW'(MAX_COLUMNS);
				PH_W:    raddr = addr - AW'(1);
				PH_E:    raddr = addr + AW'(1);
				default: raddr = addr;
			endcase
		end
	end

	assign sweep_wr = dcmd.sweep && (dcmd.phase == PH_WR);
	assign we_a     = dcmd.load_we || (sweep_wr && cur_sel_q);
	assign we_b     = dcmd.load_we || (sweep_wr && !cur_sel_q);
	assign wr_val   = dcmd.interior ? new_q : center_q;

	// the source value is always taken at the center point
	always_ff @(posedge clk) begin
		rd_a <= mem_a[raddr];
		rd_b <= mem_b[raddr];
		rd_f <= mem_f[addr];
		if (we_a) mem_a[addr] <= dcmd.load_we ? u_in_q : wr_val;
		if (we_b) mem_b[addr] <= dcmd.load_we ? u_in_q : wr_val;
		if (dcmd.load_we) mem_f[addr] <= f_in_q;
	end

	// north and south taps arrive in the s and w phases
	assign cur_rd  = cur_sel_q ? rd_b : rd_a;
	assign inv_sel = (dcmd.phase == PH_S || dcmd.phase == PH_W) ? inv_dy : inv_dx;
	assign prod_c  = $signed(cur_rd) * $signed({1'b0, inv_sel});
	assign term    = prod_q >>> 8;
	assign mag     = acc_q[59] ? 60'(-acc_q) : 60'(acc_q);
	assign qsum    = 61'(prodhi_q) + 61'((65'(prodlo_q) + 65'h0_8000_0000) >> 32);
	assign qval    = acc_q[59] ? -$signed(64'(qsum)) : $signed(64'(qsum));
	assign diff    = {new_q[31], new_q} - {center_q[31], center_q};
	assign absd_w  = diff[32] ? -diff : diff;
	assign absd    = absd_w[31:0];

	// stencil arithmetic, one step per phase
	always_ff @(posedge clk) begin
		if (dcmd.capture) begin
			u_in_q <= sat_val(64'(cmd.initial_u));
			f_in_q <= sat_val(64'(cmd.source_f));
		end
		prod_q <= prod_c[63:0];
		case (dcmd.phase)
			PH_S:    acc_q <= 60'($signed(rd_f));
			PH_W, PH_E, PH_C, PH_ACC: acc_q <= acc_q + term[59:0];
			default: acc_q <= acc_q;
		endcase
		if (dcmd.phase == PH_ACC) center_q <= cur_rd;
		if (dcmd.phase == PH_LO) prodlo_q <= 64'(mag[31:0]) * 64'(coef);
		if (dcmd.phase == PH_HI) prodhi_q <= 60'(mag[59:32]) * 60'(coef);
		if (dcmd.phase == PH_RES) new_q <= sat_val(qval);
		if (dcmd.out_load) begin
			rsp_q.status     <= dcmd.status;
			rsp_q.u_value    <= (dcmd.status == ST_READ) ? cur_rd : 32'd0;
			rsp_q.iterations <= sweep_count;
			rsp_q.max_change <= largest_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_sel_q <= 1'b0;
			worst_q   <= '0;
			largest_q <= '0;
		end else begin
			if (dcmd.swap) cur_sel_q <= !cur_sel_q;
			if (dcmd.clear_worst) worst_q <= '0;
			else if (sweep_wr && dcmd.interior && absd > worst_q) worst_q <= absd;
			if (dcmd.keep_change) largest_q <= worst_q;
		end
	end

	assign dstat.le_tol = (worst_q <= {1'b0, tol});
	assign rsp          = rsp_q;

endmodule

`default_nettype wire

@@ rtl/jps_ctrl.sv @@
// jps_ctrl: command sequencer and sweep walker
// depends on jps_pkg; drives jps_datapath
`default_nettype none

module jps_ctrl #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 128
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cmd_valid,
	output logic                                      cmd_ready,
	input  jps_pkg::cmd_t                             cmd,
	input  logic [7:0]                                cols_cfg,
	input  logic [7:0]                                rows_cfg,
	input  logic [15:0]                               limit_cfg,
	input  jps_pkg::jps_dstat_t                       dstat,
	output jps_pkg::jps_dcmd_t                        dcmd,
	output logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0]   addr,
	output logic                                      rsp_valid,
	input  logic                                      rsp_ready,
	output logic [15:0]                               sweep_count
);
	import jps_pkg::*;

	localparam int AW = $clog2(MAX_COLUMNS*MAX_ROWS);
	localparam int CW = $clog2(MAX_COLUMNS+1);
	localparam int RW = $clog2(MAX_ROWS+1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_SINIT = 3'd3;
	localparam logic [2:0] S_SWEEP = 3'd4;
	localparam logic [2:0] S_SWEND = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]    state_q;
	logic [2:0]    status_q;
	logic [3:0]    phase_q;
	logic [AW-1:0] addr_q;
	logic [CW-1:0] i_q, cols_eff;
	logic [RW-1:0] j_q, rows_eff;
	logic [15:0]   cnt_q, limit_eff;
	logic [16:0]   cnt_next;
	logic          rsp_valid_q, accept, in_range, slot_free, row_end, last_pt, interior;
	logic          copy_q, again;

	always_comb begin
		if (cols_cfg < 8'd3) cols_eff = CW'(3);
		else if (32'(cols_cfg) > MAX_COLUMNS) cols_eff = CW'(MAX_COLUMNS);
		else cols_eff = CW'(cols_cfg);
		if (rows_cfg < 8'd3) rows_eff = RW'(3);
		else if (32'(rows_cfg) > MAX_ROWS) rows_eff = RW'(MAX_ROWS);
		else rows_eff = RW'(rows_cfg);
	end

	assign limit_eff = (limit_cfg == 16'd0) ? 16'd1 : limit_cfg;
	assign cnt_next  = 17'(cnt_q) + 17'd1;
	assign again     = (cnt_next < 17'(limit_eff)) && !dstat.le_tol;
	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign in_range  = (32'(cmd.row) < 32'(rows_eff)) && (32'(cmd.col) < 32'(cols_eff));
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign row_end   = (i_q == cols_eff - CW'(1));
	assign last_pt   = row_end && (j_q == rows_eff - RW'(1));
	assign interior  = (i_q != '0) && !row_end && (j_q != '0) && (j_q != rows_eff - RW'(1));

	// the copy pass after the last sweep moves every active point unchanged
	always_comb begin
		dcmd             = '0;
		dcmd.capture     = accept;
		dcmd.load_we     = (state_q == S_LOAD);
		dcmd.sweep       = (state_q == S_SWEEP);
		dcmd.phase       = (state_q == S_SWEEP) ? phase_q : PH_N;
		dcmd.interior    = interior && !copy_q;
		dcmd.clear_worst = (state_q == S_SINIT) ||
			((state_q == S_SWEND) && !copy_q && again);
		dcmd.swap        = (state_q == S_SWEND);
		dcmd.keep_change = (state_q == S_SWEND) && !copy_q && !again;
		dcmd.out_load    = (state_q == S_DONE) && slot_free;
		dcmd.status      = status_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= ST_BAD;
			phase_q     <= PH_N;
			addr_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			copy_q      <= 1'b0;
		end else begin
			if (dcmd.out_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						addr_q <= AW'(32'(cmd.row) * MAX_COLUMNS + 32'(cmd.col));
						status_q <= ST_BAD;
						if (cmd.command == CMD_SOLVE) state_q <= S_SINIT;
						else if (cmd.command == CMD_LOAD && in_range) state_q <= S_LOAD;
						else if (cmd.command == CMD_READ && in_range) state_q <= S_RD;
						else state_q <= S_DONE;
					end
				end
				S_LOAD: begin
					status_q <= ST_LOADED;
					state_q  <= S_DONE;
				end
				S_RD: begin
					status_q <= ST_READ;
					state_q  <= S_DONE;
				end
				S_SINIT: begin
					cnt_q   <= '0;
					addr_q  <= '0;
					i_q     <= '0;
					j_q     <= '0;
					phase_q <= PH_N;
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (phase_q == PH_WR) begin
						phase_q <= PH_N;
						if (last_pt) begin
							state_q <= S_SWEND;
						end else if (row_end) begin
							i_q    <= '0;
							j_q    <= j_q + RW'(1);
							addr_q <= AW'(32'(addr_q) + MAX_COLUMNS - 32'(cols_eff) + 1);
						end else begin
							i_q    <= i_q + CW'(1);
							addr_q <= addr_q + AW'(1);
						end
					end else begin
						phase_q <= phase_q + 4'd1;
					end
				end
				S_SWEND: begin
					if (copy_q) begin
						copy_q  <= 1'b0;
						state_q <= S_DONE;
					end else begin
						cnt_q  <= cnt_next[15:0];
						addr_q <= '0;
						i_q    <= '0;
						j_q    <= '0;
						if (again) begin
							state_q <= S_SWEEP;
						end else begin
							// both buffers must agree before the grid size may change
							status_q <= dstat.le_tol ? ST_CONV : ST_LIMIT;
							copy_q   <= 1'b1;
							state_q  <= S_SWEEP;
						end
					end
				end
				S_DONE: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign addr        = addr_q;
	assign rsp_valid   = rsp_valid_q;
	assign sweep_count = cnt_q;

endmodule

`default_nettype wire

@@ rtl/jacobi_poisson_stencil_solver_unit.sv @@
// jacobi_poisson_stencil_solver_unit: top level with register file
// depends on jps_pkg, jps_ctrl and jps_datapath
`default_nettype none

// Five-point Jacobi solver for -lap(u) = f on a grid of up to MAX_COLUMNS x
// MAX_ROWS points, all values signed Q16.16. One command is handled at a time:
// a load writes u and f at one point, a read returns u at one point, a solve
// runs full sweeps until the largest change is within tolerance or the
// iteration limit is hit. Every command gives one response transfer, which
// sits in an output register until taken. In a solve, every grid point (edges
// included, where the value is copied across) walks ten phases through one
// read port of the current u buffer, the neighbor multiplier and the two
// coefficient multipliers. The u grid is double buffered and the buffers swap
// after each sweep; after the last sweep one more pass copies the active grid
// into the other buffer, so both buffers hold the same values when the grid
// size is changed later. There is no clearing pass after reset, grid entries
// must be loaded before they are used. Registers sit on an APB port at byte
// addresses 4*i and are to be written only while the block is idle; the block
// itself does not enforce this.
module jacobi_poisson_stencil_solver_unit #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 128,
	parameter int VALUE_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	// command channel
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  jps_pkg::cmd_t cmd,
	// response channel
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output jps_pkg::rsp_t rsp,
	// register port
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import jps_pkg::*;

	localparam int AW = $clog2(MAX_COLUMNS*MAX_ROWS);

	// register indexes
	localparam logic [2:0] R_COLS  = 3'd0;
	localparam logic [2:0] R_ROWS  = 3'd1;
	localparam logic [2:0] R_INVDX = 3'd2;
	localparam logic [2:0] R_INVDY = 3'd3;
	localparam logic [2:0] R_COEF  = 3'd4;
	localparam logic [2:0] R_TOL   = 3'd5;
	localparam logic [2:0] R_LIMIT = 3'd6;

	logic [7:0]  cols_q, rows_q;
	logic [31:0] inv_dx_q, inv_dy_q, coef_q;
	logic [30:0] tol_q;
	logic [15:0] limit_q;
	logic        wr_en;

	jps_dcmd_t   dcmd;
	jps_dstat_t  dstat;
	logic [AW-1:0] addr;
	logic [15:0] sweep_count;

	// write lands on the access cycle of an apb transfer
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= 8'd100;
			rows_q   <= 8'd100;
			inv_dx_q <= 32'd640000;
			inv_dy_q <= 32'd640000;
			coef_q   <= 32'd429497;
			tol_q    <= 31'd1;
			limit_q  <= 16'd10000;
		end else if (wr_en) begin
			case (paddr[4:2])
				R_COLS:  cols_q   <= pwdata[7:0];
				R_ROWS:  rows_q   <= pwdata[7:0];
				R_INVDX: inv_dx_q <= pwdata;
				R_INVDY: inv_dy_q <= pwdata;
				R_COEF:  coef_q   <= pwdata;
				R_TOL:   tol_q    <= pwdata[30:0];
				R_LIMIT: limit_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[4:2])
			R_COLS:  prdata = {24'd0, cols_q};
			R_ROWS:  prdata = {24'd0, rows_q};
			R_INVDX: prdata = inv_dx_q;
			R_INVDY: prdata = inv_dy_q;
			R_COEF:  prdata = coef_q;
			R_TOL:   prdata = {1'b0, tol_q};
			R_LIMIT: prdata = {16'd0, limit_q};
			default: prdata = 32'd0;
		endcase
	end

	// sequencer: command decode, sweep walk, iteration count
	jps_ctrl #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.cols_cfg    (cols_q),
		.rows_cfg    (rows_q),
		.limit_cfg   (limit_q),
		.dstat       (dstat),
		.dcmd        (dcmd),
		.addr        (addr),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.sweep_count (sweep_count)
	);

	// grid buffers, stencil arithmetic and response register
	jps_datapath #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.dcmd        (dcmd),
		.addr        (addr),
		.cmd         (cmd),
		.inv_dx      (inv_dx_q),
		.inv_dy      (inv_dy_q),
		.coef        (coef_q),
		.tol         (tol_q),
		.sweep_count (sweep_count),
		.dstat       (dstat),
		.rsp         (rsp)
	);

endmodule

`default_nettype wire

@@ rtl/jps_checker.sv @@
// jps_checker: port-level checks of the solver, bound to the top level
// depends on jps_pkg and jacobi_poisson_stencil_solver_unit
`default_nettype none

module jps_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_ready,
	input jps_pkg::cmd_t cmd,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input jps_pkg::rsp_t rsp,
	input logic          psel,
	input logic          penable,
	input logic          pwrite,
	input logic [4:0]    paddr,
	input logic [31:0]   pwdata,
	input logic [31:0]   prdata,
	input logic          pready
);
	import jps_pkg::*;

	// a stalled response stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// one command in flight at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while busy");

	// only a read carries u
	a_u_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_READ |-> rsp.u_value == 32'sd0)
		else $error("u value on non-read response");

	// a solve always runs at least one sweep
	a_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_CONV || rsp.status == ST_LIMIT)
		|-> rsp.iterations != 16'd0)
		else $error("solve reported zero sweeps");

endmodule

bind jacobi_poisson_stencil_solver_unit jps_checker u_jps_checker (.*);

`default_nettype wire

@@ dv/testbench.sv @@
// testbench: self-checking bench for the jacobi poisson stencil solver unit
// depends on jps_pkg and jacobi_poisson_stencil_solver_unit; holds its own solver predictor
`timescale 1ns / 1ps

module testbench;
	import jps_pkg::*;

	localparam int GRID_COLS = 128;
	localparam int GRID_ROWS = 128;
	localparam int CELLS     = GRID_COLS * GRID_ROWS;
	localparam int IDLE_MAX  = 400000;

	// register indexes on the apb port
	localparam int REG_COLUMNS = 0;
	localparam int REG_ROWS    = 1;
	localparam int REG_INV_DX  = 2;
	localparam int REG_INV_DY  = 3;
	localparam int REG_COEF    = 4;
	localparam int REG_TOL     = 5;
	localparam int REG_LIMIT   = 6;

	localparam logic [1:0] CMD_BAD = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_ready;
	cmd_t        cmd;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	jacobi_poisson_stencil_solver_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// ---------------------------------------------------------------
	// solver predictor: its own copy of the grids and the registers
	// ---------------------------------------------------------------
	logic signed [31:0] u_grid [0:CELLS-1];
	logic signed [31:0] u_sweep [0:CELLS-1];
	logic signed [31:0] f_grid [0:CELLS-1];
	bit                 was_loaded [0:CELLS-1];
	logic [15:0]        sweeps_done;
	logic [31:0]        final_change;

	logic [7:0]  cfg_cols;
	logic [7:0]  cfg_rows;
	logic [31:0] cfg_inv_dx;
	logic [31:0] cfg_inv_dy;
	logic [31:0] cfg_coef;
	logic [30:0] cfg_tol;
	logic [15:0] cfg_limit;

	// answers still owed by the block, oldest first
	rsp_t pending_answers [$];

	int mismatches;
	int answers_seen;
	bit hold_done;
	bit burst_mode;

	function automatic int active_cols();
		if (cfg_cols < 3) return 3;
		if (cfg_cols > GRID_COLS) return GRID_COLS;
		return cfg_cols;
	endfunction

	function automatic int active_rows();
		if (cfg_rows < 3) return 3;
		if (cfg_rows > GRID_ROWS) return GRID_ROWS;
		return cfg_rows;
	endfunction

	// neighbor value times inverse square, floored to Q16.16
	function automatic longint weighted(logic signed [31:0] a, logic [31:0] inv);
		longint p;
		p = longint'(a) * longint'({32'd0, inv});
		return p >>> 8;
	endfunction

	// sum times the Q0.32 coefficient, rounded half away from zero, saturated
	function automatic logic signed [31:0] scaled(longint s, logic [31:0] c);
		longint unsigned m, hi, lo, q;
		longint v;
		m = (s < 0) ? longint'(-s) : longint'(s);
		hi = m >> 32;
		lo = m & 64'hFFFF_FFFF;
		q = hi * c + ((lo * c + 64'h8000_0000) >> 32);
		v = (s < 0) ? -longint'(q) : longint'(q);
		if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -64'sh8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// one full jacobi sweep over the interior, returns the largest change
	function automatic logic [31:0] run_sweep();
		int cols, rows, k;
		logic [31:0] worst;
		logic signed [31:0] v;
		longint s, d;
		cols = active_cols();
		rows = active_rows();
		worst = 0;
		for (int j = 1; j + 1 < rows; j++)
			for (int i = 1; i + 1 < cols; i++) begin
				k = j * GRID_COLS + i;
				s = longint'(f_grid[k]) + weighted(u_grid[k - GRID_COLS], cfg_inv_dy)
					+ weighted(u_grid[k + GRID_COLS], cfg_inv_dy)
					+ weighted(u_grid[k - 1], cfg_inv_dx) + weighted(u_grid[k + 1], cfg_inv_dx);
				v = scaled(s, cfg_coef);
				d = longint'(v) - longint'(u_grid[k]);
				if (d < 0) d = -d;
				u_sweep[k] = v;
				if (d[31:0] > worst) worst = d[31:0];
			end
		for (int j = 1; j + 1 < rows; j++)
			for (int i = 1; i + 1 < cols; i++)
				u_grid[j * GRID_COLS + i] = u_sweep[j * GRID_COLS + i];
		return worst;
	endfunction

	// works out the answer to one command and updates the predicted state
	function automatic rsp_t predict_answer(cmd_t c);
		rsp_t a;
		int k, limit;
		logic [31:0] worst;
		a = '0;
		a.status = ST_BAD;
		if (c.command == CMD_SOLVE) begin
			limit = (cfg_limit == 0) ? 1 : cfg_limit;
			sweeps_done = 0;
			do begin
				worst = run_sweep();
				sweeps_done++;
			end while (sweeps_done < limit && worst > {1'b0, cfg_tol});
			final_change = worst;
			a.status = (worst <= {1'b0, cfg_tol}) ? ST_CONV : ST_LIMIT;
		end else if (c.command == CMD_LOAD || c.command == CMD_READ) begin
			if (c.row < active_rows() && c.col < active_cols()) begin
				k = c.row * GRID_COLS + c.col;
				if (c.command == CMD_LOAD) begin
					u_grid[k] = c.initial_u;
					f_grid[k] = c.source_f;
					was_loaded[k] = 1'b1;
					a.status = ST_LOADED;
				end else begin
					a.u_value = u_grid[k];
					a.status = ST_READ;
				end
			end
		end
		a.iterations = sweeps_done;
		a.max_change = final_change;
		return a;
	endfunction

	// ---------------------------------------------------------------
	// register writes over apb, setup then access
	// ---------------------------------------------------------------
	task automatic write_reg(int idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 5'(4 * idx);
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_COLUMNS: cfg_cols   = value[7:0];
			REG_ROWS:    cfg_rows   = value[7:0];
			REG_INV_DX:  cfg_inv_dx = value;
			REG_INV_DY:  cfg_inv_dy = value;
			REG_COEF:    cfg_coef   = value;
			REG_TOL:     cfg_tol    = value[30:0];
			default:     cfg_limit  = value[15:0];
		endcase
	endtask

	task automatic set_config(logic [7:0] cols, logic [7:0] rows, logic [31:0] idx2,
		logic [31:0] idy2, logic [31:0] coef, logic [30:0] tol, logic [15:0] limit);
		write_reg(REG_COLUMNS, {24'd0, cols});
		write_reg(REG_ROWS, {24'd0, rows});
		write_reg(REG_INV_DX, idx2);
		write_reg(REG_INV_DY, idy2);
		write_reg(REG_COEF, coef);
		write_reg(REG_TOL, {1'b0, tol});
		write_reg(REG_LIMIT, {16'd0, limit});
	endtask

	// ---------------------------------------------------------------
	// command side: random gap, then hold valid until the transfer
	// ---------------------------------------------------------------
	task automatic send_cmd(cmd_t c, bit typed, rsp_t typed_answer);
		int gap;
		rsp_t a;
		gap = burst_mode ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		a = predict_answer(c);
		// typed rows are checked against the hand-written answer instead
		if (typed) a = typed_answer;
		pending_answers.push_back(a);
		@(negedge clk);
	endtask

	// idle the command side until every answer is back, plus the block's latency
	task automatic drain();
		cmd_valid <= 1'b0;
		while (pending_answers.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic cmd_t make_cmd(logic [1:0] op, int r, int c, logic [31:0] u,
		logic [31:0] f);
		cmd_t x;
		x.command   = op;
		x.row       = 7'(r);
		x.col       = 7'(c);
		x.initial_u = u;
		x.source_f  = f;
		return x;
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_inv();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'd256 * $urandom_range(1, 64);
			default: return $urandom;
		endcase
	endfunction

	// fill every point of the active grid that has never been loaded
	task automatic load_missing();
		rsp_t none;
		none = '0;
		for (int r = 0; r < active_rows(); r++)
			for (int c = 0; c < active_cols(); c++)
				if (!was_loaded[r * GRID_COLS + c])
					send_cmd(make_cmd(CMD_LOAD, r, c, rand_value(), rand_value()), 1'b0, none);
	endtask

	// one random item against the current grid
	task automatic random_item();
		rsp_t none;
		int pick, r, c;
		none = '0;
		pick = $urandom_range(0, 99);
		r = $urandom_range(0, active_rows() - 1);
		c = $urandom_range(0, active_cols() - 1);
		if (pick < 4) begin
			send_cmd(make_cmd(CMD_SOLVE, $urandom_range(0, 127), $urandom_range(0, 127),
				$urandom, $urandom), 1'b0, none);
		end else if (pick < 10) begin
			send_cmd(make_cmd(CMD_BAD, $urandom_range(0, 127), $urandom_range(0, 127),
				$urandom, $urandom), 1'b0, none);
		end else if (pick < 20) begin
			// index past the active grid on one axis
			if ($urandom_range(0, 1) && active_rows() < 128) r = $urandom_range(active_rows(), 127);
			else if (active_cols() < 128) c = $urandom_range(active_cols(), 127);
			else r = $urandom_range(active_rows(), 127);
			send_cmd(make_cmd($urandom_range(0, 1) ? CMD_LOAD : CMD_READ, r, c, $urandom,
				$urandom), 1'b0, none);
		end else if (pick < 55) begin
			send_cmd(make_cmd(CMD_READ, r, c, $urandom, $urandom), 1'b0, none);
		end else begin
			send_cmd(make_cmd(CMD_LOAD, r, c, rand_value(), rand_value()), 1'b0, none);
		end
	endtask

	// directed table, walked once under a 3x3 grid
	typedef struct {
		cmd_t c;
		bit   typed;
		rsp_t a;
	} table_row_t;

	table_row_t directed [$];

	function automatic void add_row(cmd_t c, bit typed, logic [2:0] st, logic [31:0] v);
		table_row_t t;
		t.c = c;
		t.typed = typed;
		t.a = '0;
		t.a.status = st;
		t.a.u_value = v;
		directed.push_back(t);
	endfunction

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		int cols, rows, lim, phase_items;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		burst_mode = 1'b0;
		for (int k = 0; k < CELLS; k++) begin
			u_grid[k] = '0;
			u_sweep[k] = '0;
			f_grid[k] = '0;
			was_loaded[k] = 1'b0;
		end
		sweeps_done  = '0;
		final_change = '0;
		cfg_cols   = 8'd100;
		cfg_rows   = 8'd100;
		cfg_inv_dx = 32'd640000;
		cfg_inv_dy = 32'd640000;
		cfg_coef   = 32'd429497;
		cfg_tol    = 31'd1;
		cfg_limit  = 16'd10000;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// grid sizes below the minimum clamp to 3x3; zero limit acts as one sweep
		set_config(8'd0, 8'd2, 32'd256, 32'd0, 32'hFFFF_FFFF, 31'd0, 16'd0);

		add_row(make_cmd(CMD_LOAD, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000), 1, ST_LOADED, 0);
		add_row(make_cmd(CMD_LOAD, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF), 1, ST_LOADED, 0);
		add_row(make_cmd(CMD_LOAD, 0, 2, 32'h0001_0000, 32'hFFFF_FFFF), 1, ST_LOADED, 0);
		add_row(make_cmd(CMD_LOAD, 1, 0, 32'hFFFF_0000, 32'd0), 1, ST_LOADED, 0);
		add_row(make_cmd(CMD_LOAD, 1, 1, 32'h0000_8000, 32'h7FFF_FFFF), 1, ST_LOADED, 0);
		add_row(make_cmd(CMD_LOAD, 1, 2, 32'h5555_5555, 32'hAAAA_AAAA), 1, ST_LOADED, 0);
		add_row(make_cmd(CMD_LOAD, 2, 0, 32'hAAAA_AAAA, 32'h5555_5555), 1, ST_LOADED, 0);
		add_row(make_cmd(CMD_LOAD, 2, 1, 32'd0, 32'd1), 1, ST_LOADED, 0);
		add_row(make_cmd(CMD_LOAD, 2, 2, 32'hFFFF_FFFF, 32'h8000_0000), 1, ST_LOADED, 0);
		// index out of range on each axis, and the unused command code
		add_row(make_cmd(CMD_LOAD, 3, 0, 32'h1234_5678, 32'h1), 1, ST_BAD, 0);
		add_row(make_cmd(CMD_READ, 0, 127, 0, 0), 1, ST_BAD, 0);
		add_row(make_cmd(CMD_READ, 127, 127, 0, 0), 1, ST_BAD, 0);
		add_row(make_cmd(CMD_BAD, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, ST_BAD, 0);
		add_row(make_cmd(CMD_READ, 0, 0, 0, 0), 1, ST_READ, 32'h7FFF_FFFF);
		add_row(make_cmd(CMD_READ, 2, 2, 0, 0), 1, ST_READ, 32'hFFFF_FFFF);
		// solve with zero tolerance at a one-sweep limit, then read back
		add_row(make_cmd(CMD_SOLVE, 0, 0, 0, 0), 0, ST_BAD, 0);
		add_row(make_cmd(CMD_READ, 1, 1, 0, 0), 0, ST_BAD, 0);
		add_row(make_cmd(CMD_READ, 0, 1, 0, 0), 0, ST_BAD, 0);
		add_row(make_cmd(CMD_SOLVE, 0, 0, 0, 0), 0, ST_BAD, 0);
		add_row(make_cmd(CMD_READ, 1, 1, 0, 0), 0, ST_BAD, 0);
		foreach (directed[i]) begin
			directed[i].a.iterations = sweeps_done;
			directed[i].a.max_change = final_change;
			send_cmd(directed[i].c, directed[i].typed, directed[i].a);
		end
		drain();

		// random phases, each under its own register setting
		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
				0: begin
					// widest grid, zero coefficient: settles within two sweeps under the top limit
					set_config(8'd255, 8'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
						31'h7FFF_FFFF, 16'hFFFF);
				end
				1: begin
					set_config(8'd4, 8'd4, 32'd640000, 32'd640000, 32'd429497, 31'd1, 16'd20);
				end
				default: begin
					cols = $urandom_range(3, 10);
					rows = $urandom_range(3, 10);
					lim = $urandom_range(1, 1200 / (cols * rows));
					set_config(8'(cols), 8'(rows), rand_inv(), rand_inv(),
						($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom,
						($urandom_range(0, 2) == 0) ? 31'h7FFF_FFFF : 31'($urandom_range(0, 4096)),
						16'(lim));
				end
			endcase
			load_missing();
			phase_items = 0;
			while (phase_items < 20) begin
				// every ten items, choose at random a run with or without gaps
				if (phase_items % 10 == 0) burst_mode = ($urandom_range(0, 2) == 0);
				random_item();
				phase_items++;
			end
			burst_mode = 1'b0;
			drain();
		end

		cmd_valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// ---------------------------------------------------------------
	// response side: random stalls, and one long hold-off to back up the block
	// ---------------------------------------------------------------
	initial begin
		int n;
		rsp_ready = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && answers_seen >= 120) begin
				n = 300;
				hold_done = 1'b1;
			end else begin
				n = burst_mode ? 0 : $urandom_range(0, 10);
			end
			if (n > 0) begin
				rsp_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	// compare each response transfer with the oldest owed answer
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			answers_seen <= answers_seen + 1;
			if (pending_answers.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected response transfer: %p", rsp);
			end else begin
				want = pending_answers.pop_front();
				if (rsp.status !== want.status || rsp.u_value !== want.u_value
						|| rsp.iterations !== want.iterations
						|| rsp.max_change !== want.max_change) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("response mismatch: expected %p, got %p", want, rsp);
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		answers_seen = 0;
	end

	// watchdog on cycles without any transfer
	int idle_cycles;
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_MAX) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
